### src/xoshiro256ss_random_generator_unit_defines.svh
// Assertion macros for the xoshiro256** generator unit.
// Used by the top level only; empty bodies under SYNTHESIS.
`ifndef XOSHIRO256SS_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`define XOSHIRO256SS_RANDOM_GENERATOR_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define XRG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define XRG_ASSERT_IMPL(lbl, ante, cons, msg)
`define XRG_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### src/xrg_pkg.sv
// Shared types, constants and helpers for the xoshiro256** generator unit.
// No dependencies.
`timescale 1ns / 1ps
package xrg_pkg;
  typedef enum logic [2:0] {
    OP_RESEED = 3'd0, OP_RAW = 3'd1, OP_UINT = 3'd2, OP_FRAC = 3'd3, OP_BERN = 3'd4
  } op_t;

  // Front part: run, or one of the four phases of a SplitMix64 step
  typedef enum logic [2:0] {
    F_RUN, F_MIX_A, F_MIX_B, F_MIX_C, F_MIX_D
  } fstate_t;

  localparam logic [63:0] MIX_GAMMA = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] MIX_MUL1  = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_MUL2  = 64'h94D049BB133111EB;
  localparam logic [53:0] FRAC_ONE  = 54'h20000000000000;
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = $clog2(QDEPTH);

  // Word handed from the front to the back part.
  typedef struct packed {
    logic        reseed;
    logic [2:0]  op;
    logic [63:0] raw;
    logic [31:0] low;
    logic [32:0] size;
    logic [53:0] prob;
  } job_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned k);
    rotl = (x << k) | (x >> (64 - k));
  endfunction
endpackage

### src/xrg_mul64.sv
// 64x64 low-half multiplier built from 32x32 partial products.
// No dependencies.
`timescale 1ns / 1ps
module xrg_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] prod
);
  logic [1:0]  step_r, step_nxt;
  logic        busy_r, busy_nxt;
  logic [63:0] a_r, b_r, acc_r, acc_nxt;
  logic [31:0] x, y;
  logic [63:0] pp_r;
  logic        pv_r;

  always_comb begin
    case (step_r)
      2'd0: begin x = a_r[31:0];  y = b_r[31:0];  end
      2'd1: begin x = a_r[63:32]; y = b_r[31:0];  end
      2'd2: begin x = a_r[31:0];  y = b_r[63:32]; end
      default: begin x = 32'd0; y = 32'd0; end
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    acc_nxt  = acc_r;
    if (pv_r) begin
      case (step_r)
        2'd1: acc_nxt = pp_r;
        2'd2: acc_nxt = acc_r + {pp_r[31:0], 32'd0};
        2'd3: acc_nxt = acc_r + {pp_r[31:0], 32'd0};
        default: acc_nxt = acc_r;
      endcase
    end
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = 2'd0;
    end else if (busy_r) begin
      step_nxt = step_r + 2'd1;
      if (step_r == 2'd3) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= 2'd0;
      pv_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
      pv_r   <= busy_r && step_r != 2'd3;
    end
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    pp_r  <= {32'd0, x} * {32'd0, y};
    acc_r <= acc_nxt;
  end

  assign done = busy_r && step_r == 2'd3;
  assign prod = acc_r + {pp_r[31:0], 32'd0};
endmodule

### src/xrg_front.sv
// Front part: holds generator state and seed, advances state, expands the seed.
// Classifies each request into a job word. Depends on xrg_pkg, xrg_mul64.
`timescale 1ns / 1ps
module xrg_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [63:0]        cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_op,
  input  logic [31:0]        in_low,
  input  logic [31:0]        in_high,
  input  logic [53:0]        in_prob,
  output logic               job_valid,
  input  logic               job_ready,
  output xrg_pkg::job_t      job,
  output xrg_pkg::seq_stat_t stat
);
  xrg_pkg::fstate_t st_r, st_nxt;
  logic [63:0] s0_r, s1_r, s2_r, s3_r;
  logic [63:0] seed_r, acc_r, z_r;
  logic [1:0]  widx_r;
  logic        emit_r;
  logic        mstart;
  logic [63:0] ma, mb, mprod;
  logic        mdone;
  logic        adv;
  logic [63:0] t1, raw, zfin;
  logic signed [32:0] lo_s, hi_s;
  logic [31:0] lo_sel;
  logic [32:0] diff;

  xrg_mul64 u_mul (
    .clk(clk), .rst_n(rst_n), .start(mstart), .a(ma), .b(mb), .done(mdone), .prod(mprod)
  );

  // ** scrambler: x*5 and *9 are shift-adds
  assign t1  = (s1_r << 2) + s1_r;
  assign raw = (xrg_pkg::rotl(t1, 7) << 3) + xrg_pkg::rotl(t1, 7);

  assign lo_s   = {in_low[31], in_low};
  assign hi_s   = {in_high[31], in_high};
  assign lo_sel = (lo_s > hi_s) ? in_high : in_low;
  assign diff   = (lo_s > hi_s) ? (lo_s - hi_s) : (hi_s - lo_s);

  assign in_ready = (st_r == xrg_pkg::F_RUN) && !emit_r && (job_ready || !job_valid);
  assign adv      = in_valid && in_ready && in_op != xrg_pkg::OP_RESEED;
  assign zfin     = mprod ^ (mprod >> 31);

  always_comb begin
    st_nxt = st_r;
    mstart = 1'b0;
    ma     = 64'd0;
    mb     = 64'd0;
    case (st_r)
      xrg_pkg::F_RUN:
        if (in_valid && in_ready && in_op == xrg_pkg::OP_RESEED) st_nxt = xrg_pkg::F_MIX_A;
      xrg_pkg::F_MIX_A: begin
        mstart = 1'b1;
        ma = acc_r ^ (acc_r >> 30);
        mb = xrg_pkg::MIX_MUL1;
        st_nxt = xrg_pkg::F_MIX_B;
      end
      xrg_pkg::F_MIX_B: if (mdone) st_nxt = xrg_pkg::F_MIX_C;
      xrg_pkg::F_MIX_C: begin
        mstart = 1'b1;
        ma = z_r ^ (z_r >> 27);
        mb = xrg_pkg::MIX_MUL2;
        st_nxt = xrg_pkg::F_MIX_D;
      end
      xrg_pkg::F_MIX_D:
        if (mdone) st_nxt = (widx_r == 2'd3) ? xrg_pkg::F_RUN : xrg_pkg::F_MIX_A;
      default: st_nxt = xrg_pkg::F_RUN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= xrg_pkg::F_MIX_A;
      seed_r    <= 64'd0;
      acc_r     <= xrg_pkg::MIX_GAMMA;
      widx_r    <= 2'd0;
      emit_r    <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) seed_r <= cfg_wdata;
      if (job_valid && job_ready) job_valid <= 1'b0;
      if (st_r == xrg_pkg::F_RUN && in_valid && in_ready) begin
        if (in_op == xrg_pkg::OP_RESEED) begin
          acc_r  <= seed_r + xrg_pkg::MIX_GAMMA;
          widx_r <= 2'd0;
          emit_r <= 1'b1;
        end else begin
          job_valid <= 1'b1;
        end
      end
      if (st_r == xrg_pkg::F_MIX_D && mdone) begin
        widx_r <= widx_r + 2'd1;
        acc_r  <= acc_r + xrg_pkg::MIX_GAMMA;
        if (widx_r == 2'd3 && emit_r) begin
          emit_r    <= 1'b0;
          job_valid <= 1'b1;
        end
      end
    end
    if (st_r == xrg_pkg::F_MIX_B && mdone) z_r <= mprod;
    if (st_r == xrg_pkg::F_MIX_D && mdone) begin
      case (widx_r)
        2'd0: s0_r <= zfin;
        2'd1: s1_r <= zfin;
        2'd2: s2_r <= zfin;
        default: s3_r <= zfin;
      endcase
    end
    if (adv) begin
      s2_r <= s2_r ^ s0_r ^ (s1_r << 17);
      s3_r <= xrg_pkg::rotl(s3_r ^ s1_r, 45);
      s1_r <= s1_r ^ s2_r ^ s0_r;
      s0_r <= s0_r ^ s3_r ^ s1_r;
    end
    if (adv) begin
      job.reseed <= 1'b0;
      job.op     <= in_op;
      job.raw    <= raw;
      job.low    <= lo_sel;
      job.size   <= diff + 33'd1;
      job.prob   <= (in_prob > xrg_pkg::FRAC_ONE) ? xrg_pkg::FRAC_ONE : in_prob;
    end else if (st_r == xrg_pkg::F_RUN && in_valid && in_ready) begin
      job.reseed <= 1'b1;
      job.op     <= in_op;
      job.raw    <= 64'd0;
      job.low    <= 32'd0;
      job.size   <= 33'd1;
      job.prob   <= 54'd0;
    end
  end

  assign stat.busy = st_r != xrg_pkg::F_RUN;
  assign stat.done = st_r == xrg_pkg::F_MIX_D && mdone && widx_r == 2'd3;
endmodule

### src/xrg_queue.sv
// Short job queue between the front and back parts.
// Depends on xrg_pkg.
`timescale 1ns / 1ps
module xrg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  xrg_pkg::job_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output xrg_pkg::job_t rd_data
);
  xrg_pkg::job_t mem [xrg_pkg::QDEPTH];
  logic [xrg_pkg::QAW-1:0] wp_r, rp_r;
  logic [xrg_pkg::QAW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_ready = cnt_r != (xrg_pkg::QAW+1)'(xrg_pkg::QDEPTH);
  assign rd_valid = cnt_r != '0;
  assign wr_en    = wr_valid && wr_ready;
  assign rd_en    = rd_valid && rd_ready;
  assign rd_data  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (xrg_pkg::QAW+1)'(wr_en) - (xrg_pkg::QAW+1)'(rd_en);
    end
    if (wr_en) mem[wp_r] <= wr_data;
  end
endmodule

### src/xrg_back.sv
// Back part: range reduction by restoring division, Bernoulli compare, output register.
// Depends on xrg_pkg.
`timescale 1ns / 1ps
module xrg_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  xrg_pkg::job_t job,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [63:0]   raw_word,
  output logic [31:0]   int_value,
  output logic [52:0]   fraction,
  output logic          hit
);
  logic        busy_r;
  logic [5:0]  cnt_r;
  logic [32:0] rem_r, size_r, rem_nxt;
  logic [63:0] q_r;
  logic [33:0] trial;
  logic [31:0] low_r;
  logic        take;

  // one quotient bit per cycle: remainder of raw mod size
  assign trial   = {rem_r, q_r[63]} - {1'b0, size_r};
  assign rem_nxt = trial[33] ? {rem_r[31:0], q_r[63]} : trial[32:0];

  assign job_ready = !busy_r && !out_valid;
  assign take      = job_valid && job_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
      cnt_r     <= 6'd0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (take) begin
        if (job.op == xrg_pkg::OP_UINT) begin
          busy_r <= 1'b1;
          cnt_r  <= 6'd0;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd63) begin
          busy_r    <= 1'b0;
          out_valid <= 1'b1;
        end
      end
    end
    if (take) begin
      raw_word  <= job.raw;
      fraction  <= job.raw[63:11];
      int_value <= 32'd0;
      hit       <= job.op == xrg_pkg::OP_BERN && !job.reseed &&
                   {1'b0, job.raw[63:11]} < job.prob;
      rem_r     <= 33'd0;
      q_r       <= job.raw;
      size_r    <= job.size;
      low_r     <= job.low;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[62:0], 1'b0};
      if (cnt_r == 6'd63) int_value <= low_r + rem_nxt[31:0];
    end
  end
endmodule

### src/xoshiro256ss_random_generator_unit.sv
// xoshiro256** generator: front advances state, back reduces and registers results.
// Raw/fraction/Bernoulli results are registered in the back part; the uniform integer is
// reduced one remainder bit per cycle. Reseed runs four SplitMix64 steps, each of two
// multiplies with an issue state before each, and holds off input while they run.
// The back part takes a new job only once its previous result has been accepted.
// Synchronous active-low reset; after reset the state expands seed 0.
`timescale 1ns / 1ps
`include "xoshiro256ss_random_generator_unit_defines.svh"
module xoshiro256ss_random_generator_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [127:0] in_tdata,  // opcode[2:0], low_bound[34:3], high_bound[66:35], probability[120:67]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [151:0] out_tdata  // raw_word[63:0], int_value[95:64], fraction[148:96], hit[149]
);
  xrg_pkg::job_t      fjob, qjob;
  xrg_pkg::seq_stat_t stat;
  logic fv, fr, qv, qr;
  logic [63:0] raw_word;
  logic [31:0] int_value;
  logic [52:0] fraction;
  logic        hit;

  xrg_front u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_tvalid), .in_ready(in_tready), .in_op(in_tdata[2:0]),
    .in_low(in_tdata[34:3]), .in_high(in_tdata[66:35]), .in_prob(in_tdata[120:67]),
    .job_valid(fv), .job_ready(fr), .job(fjob), .stat(stat)
  );

  xrg_queue u_queue (
    .clk(clk), .rst_n(rst_n), .wr_valid(fv), .wr_ready(fr), .wr_data(fjob),
    .rd_valid(qv), .rd_ready(qr), .rd_data(qjob)
  );

  xrg_back u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(qv), .job_ready(qr), .job(qjob),
    .out_valid(out_tvalid), .out_ready(out_tready), .raw_word(raw_word),
    .int_value(int_value), .fraction(fraction), .hit(hit)
  );

  assign out_tdata = {2'b00, hit, fraction, int_value, raw_word};

  `XRG_ASSERT_IMPL(a_busy_no_accept, stat.busy, !in_tready, "accept during seed expansion")
  `XRG_ASSERT_NEXT(a_done_idle, stat.done, !stat.busy, "seed expansion did not finish")
  `XRG_ASSERT_IMPL(a_out_zero_hit, out_tvalid && out_tdata[149], out_tdata[95:64] == 32'd0,
    "hit with nonzero integer")
endmodule

### verif/xrg_checker.sv
// Checker for the xoshiro256** generator unit: watches the input, config and output
// channels, predicts each result word and compares. Depends on xrg_pkg.
`timescale 1ns / 1ps
module xrg_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [63:0]  cfg_wdata,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [127:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [151:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  typedef struct packed {
    logic [63:0] raw;
    logic [31:0] ival;
    logic [52:0] frac;
    logic        hit;
  } rng_result_t;

  logic [63:0] seed_reg;
  logic [63:0] st [4];
  rng_result_t result_q[$];

  // four SplitMix64 steps into the state words
  function automatic void expand(input logic [63:0] s);
    logic [63:0] acc, z;
    acc = s;
    for (int i = 0; i < 4; i++) begin
      acc = acc + xrg_pkg::MIX_GAMMA;
      z = acc;
      z = (z ^ (z >> 30)) * xrg_pkg::MIX_MUL1;
      z = (z ^ (z >> 27)) * xrg_pkg::MIX_MUL2;
      st[i] = z ^ (z >> 31);
    end
  endfunction

  function automatic rng_result_t predict_word(input logic [127:0] d);
    rng_result_t r;
    logic [2:0] op;
    logic [63:0] w, t, lo, hi, sz, v;
    logic [53:0] p;
    op = d[2:0];
    r = '0;
    if (op == xrg_pkg::OP_RESEED) begin
      expand(seed_reg);
      return r;
    end
    w = st[1] * 64'd5;
    w = ((w << 7) | (w >> 57)) * 64'd9;
    t = st[1] << 17;
    st[2] ^= st[0];
    st[3] ^= st[1];
    st[1] ^= st[2];
    st[0] ^= st[3];
    st[2] ^= t;
    st[3] = (st[3] << 45) | (st[3] >> 19);
    r.raw = w;
    r.frac = w[63:11];
    if (op == xrg_pkg::OP_UINT) begin
      lo = {{32{d[34]}}, d[34:3]};
      hi = {{32{d[66]}}, d[66:35]};
      if ($signed(lo) > $signed(hi)) begin
        t = lo; lo = hi; hi = t;
      end
      sz = hi - lo + 64'd1;
      v = lo + (w % sz);
      r.ival = v[31:0];
    end else if (op == xrg_pkg::OP_BERN) begin
      p = d[120:67];
      if (p > xrg_pkg::FRAC_ONE) p = xrg_pkg::FRAC_ONE;
      r.hit = ({1'b0, w[63:11]} < p);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    rng_result_t e, a;
    if (!rst_n) begin
      seed_reg <= '0;
      expand(64'd0);
      result_q.delete();
      fail_count <= 0;
      pending <= 0;
    end else begin
      // predict before the seed write of this edge takes effect
      if (in_tvalid && in_tready) result_q.push_back(predict_word(in_tdata));
      if (cfg_we) seed_reg <= cfg_wdata;
      if (out_tvalid && out_tready) begin
        a.raw = out_tdata[63:0];
        a.ival = out_tdata[95:64];
        a.frac = out_tdata[148:96];
        a.hit = out_tdata[149];
        if (result_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result word %h", out_tdata);
          fail_count <= fail_count + 1;
        end else begin
          e = result_q.pop_front();
          if (e != a) begin
            if (fail_count < 10)
              $display("mismatch: exp raw=%h int=%h frac=%h hit=%b, %s",
                       e.raw, e.ival, e.frac, e.hit, "got:");
            if (fail_count < 10)
              $display("          got raw=%h int=%h frac=%h hit=%b",
                       a.raw, a.ival, a.frac, a.hit);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= result_q.size();
    end
  end
endmodule

### verif/tb_xoshiro256ss_random_generator_unit.sv
// Testbench top: drives requests and seed writes into the xoshiro256** unit with random
// idling and back-pressure; xrg_checker predicts and compares. Depends on xrg_pkg.
`timescale 1ns / 1ps
module tb_xoshiro256ss_random_generator_unit;
  localparam int WATCHDOG = 20000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [63:0] cfg_wdata = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [127:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [151:0] out_tdata;
  int fail_count, pending;
  int idle_pct = 13;
  bit hold_off = 0;
  int stall_cycles = 0;
  int n_sent = 0;
  int quiet = 0;

  always #5 clk = ~clk;

  xoshiro256ss_random_generator_unit DUT (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  xrg_checker u_checker (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  // receiver: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    if (hold_off) begin
      out_tready <= 1'b0;
      stall_cycles <= stall_cycles + 1;
    end else begin
      out_tready <= ($urandom_range(99) >= idle_pct);
    end
  end

  // watchdog: cycles without any accepted word
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("watchdog expired");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [127:0] pack_req(input logic [2:0] op, input logic [31:0] lo,
                                            input logic [31:0] hi, input logic [53:0] p);
    return {7'd0, p, hi, lo, op};
  endfunction

  task automatic send(input logic [127:0] d);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    n_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_seed(input logic [63:0] s);
    cfg_we <= 1'b1;
    cfg_wdata <= s;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [127:0] random_req();
    logic [2:0] op;
    logic [31:0] lo, hi;
    logic [53:0] p;
    op = 3'($urandom_range(7));
    lo = $urandom;
    hi = $urandom;
    case ($urandom_range(3))
      0: hi = lo + $urandom_range(15);
      1: lo = hi;
      default: ;
    endcase
    p = 54'({$urandom, $urandom});
    if ($urandom_range(3) != 0) p = {1'b0, p[52:0]};
    // reseed rarely so long sequences get exercised
    if (op == xrg_pkg::OP_RESEED && $urandom_range(9) != 0) op = xrg_pkg::OP_RAW;
    return pack_req(op, lo, hi, p);
  endfunction

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    repeat (40) @(posedge clk);

    // directed: every op, bound and probability extremes
    send(pack_req(xrg_pkg::OP_RAW, '0, '0, '0));
    send(pack_req(xrg_pkg::OP_FRAC, '0, '0, '0));
    send(pack_req(3'd5, '0, '0, '0));
    send(pack_req(3'd6, '0, '0, '0));
    send(pack_req(3'd7, '1, '1, '1));
    send(pack_req(xrg_pkg::OP_UINT, 32'h80000000, 32'h7FFFFFFF, '0));
    send(pack_req(xrg_pkg::OP_UINT, 32'h7FFFFFFF, 32'h80000000, '0));
    send(pack_req(xrg_pkg::OP_UINT, 32'd5, 32'd5, '0));
    send(pack_req(xrg_pkg::OP_UINT, 32'd10, 32'hFFFFFFF6, '0));
    send(pack_req(xrg_pkg::OP_UINT, 32'hFFFFFFFF, 32'd0, '0));
    send(pack_req(xrg_pkg::OP_BERN, '0, '0, 54'd0));
    send(pack_req(xrg_pkg::OP_BERN, '0, '0, xrg_pkg::FRAC_ONE));
    send(pack_req(xrg_pkg::OP_BERN, '0, '0, '1));
    send(pack_req(xrg_pkg::OP_BERN, '0, '0, 54'h10000000000000));
    send(pack_req(xrg_pkg::OP_BERN, '0, '0, 54'd1));
    send(pack_req(xrg_pkg::OP_RESEED, '1, '1, '1));
    send(pack_req(xrg_pkg::OP_RAW, '0, '0, '0));
    drain();

    // seed phases, extremes among them
    write_seed(64'hFFFFFFFFFFFFFFFF);
    send(pack_req(xrg_pkg::OP_RESEED, '0, '0, '0));
    send(pack_req(xrg_pkg::OP_RAW, '0, '0, '0));
    send(pack_req(xrg_pkg::OP_UINT, 32'h80000000, 32'h7FFFFFFF, '0));
    drain();
    write_seed(64'd1);
    send(pack_req(xrg_pkg::OP_RESEED, '0, '0, '0));
    send(pack_req(xrg_pkg::OP_FRAC, '0, '0, '0));
    drain();

    // long receiver hold-off while requests keep coming
    hold_off <= 1'b1;
    fork
      begin
        while (stall_cycles < 300) @(posedge clk);
        hold_off <= 1'b0;
      end
      for (int k = 0; k < 40; k++) send(random_req());
    join
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      write_seed({$urandom, $urandom});
      idle_pct = (ph == 2) ? 0 : 13;
      for (int k = 0; k < 380; k++) send(random_req());
      drain();
    end
    write_seed(64'd0);
    send(pack_req(xrg_pkg::OP_RESEED, '0, '0, '0));
    send(pack_req(xrg_pkg::OP_RAW, '0, '0, '0));
    drain();

    $display("sent %0d requests over several seed settings, all opcodes, bound and", n_sent);
    $display("probability extremes, random idling and a 300-cycle output stall");
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
